### rtl/clipped_argb_alpha_blit_unit_defines.svh
// Assertion macros for the blit unit. Every check is clocked on clock and
// is switched off while reset is high.
`ifndef CLIPPED_ARGB_ALPHA_BLIT_UNIT_DEFINES_SVH
`define CLIPPED_ARGB_ALPHA_BLIT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CAB_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CAB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CAB_ASSERT_IMPLY(lbl, ante, cons, msg)
`define CAB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/cab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cab_pkg;

   // Default clip limit for the destination size.
   localparam int MAX_DIM_DEFAULT = 4096;

   // Field widths.
   localparam int OFFSET_W = 14;
   localparam int DIM_W    = 13;
   localparam int ALPHA_W  = 8;
   localparam int COORD_W  = 12;
   localparam int COLOR_W  = 32;
   localparam int ADDR_W   = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   // Pipeline depth, output register included.
   localparam int NUM_STAGES = 4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_WIDTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_ALPHA = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [DIM_W-1:0]   DIM_RESET   = 13'd4096;
   localparam logic [ALPHA_W-1:0] ALPHA_FULL  = 8'hff;

   typedef struct packed {
      logic signed [OFFSET_W-1:0] offset_x;
      logic signed [OFFSET_W-1:0] offset_y;
      logic [DIM_W-1:0]           dest_width;
      logic [DIM_W-1:0]           dest_height;
      logic [ALPHA_W-1:0]         global_alpha;
   } cfg_type;

   // Per-stage load enables shared by both datapaths.
   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } stage_ctrl_type;

   // Floor of x / 255 for any 16-bit x up to 65279, by reciprocal with correction.
   function automatic logic [ALPHA_W-1:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'd1 + 17'(x[15:8]);
      return t[15:8];
   endfunction

endpackage

`default_nettype wire

### rtl/cab_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module cab_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [cab_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [cab_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output cab_pkg::cfg_type                      cfg
);

   cab_pkg::cfg_type cfg_ff;
   cab_pkg::cfg_type cfg_in;

   // Decode the write; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            cab_pkg::CSR_OFFSET_X:     cfg_in.offset_x     = $signed(csr_wdata);
            cab_pkg::CSR_OFFSET_Y:     cfg_in.offset_y     = $signed(csr_wdata);
            cab_pkg::CSR_DEST_WIDTH:   cfg_in.dest_width   = csr_wdata[cab_pkg::DIM_W-1:0];
            cab_pkg::CSR_DEST_HEIGHT:  cfg_in.dest_height  = csr_wdata[cab_pkg::DIM_W-1:0];
            cab_pkg::CSR_GLOBAL_ALPHA: cfg_in.global_alpha = csr_wdata[cab_pkg::ALPHA_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_x     <= '0;
         cfg_ff.offset_y     <= '0;
         cfg_ff.dest_width   <= cab_pkg::DIM_RESET;
         cfg_ff.dest_height  <= cab_pkg::DIM_RESET;
         cfg_ff.global_alpha <= cab_pkg::ALPHA_FULL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/cab_geom.sv
`timescale 1ns / 1ps
`default_nettype none

module cab_geom #(
   parameter int MAX_DIM = cab_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                             clock,
   input  wire cab_pkg::stage_ctrl_type          ctrl,
   input  wire cab_pkg::cfg_type                 cfg,
   input  wire logic [cab_pkg::COORD_W-1:0]      src_x,
   input  wire logic [cab_pkg::COORD_W-1:0]      src_y,
   input  wire logic                             last_in,
   output logic                                  inside_s3,
   output logic                                  write_enable,
   output logic [cab_pkg::ADDR_W-1:0]            dest_address,
   output logic                                  last_out
);

   localparam int DIM_W = cab_pkg::DIM_W;
   localparam int POS_W = cab_pkg::OFFSET_W + 1;
   localparam int PROD_W = 2 * DIM_W;

   // Stage 1: offset position, clamp destination size.
   logic signed [POS_W-1:0] bx_ff, bx_in, by_ff, by_in;
   logic [DIM_W-1:0]        wc_ff, wc_in, hc_ff, hc_in;
   logic                    last1_ff;

   always_comb begin
      bx_in = $signed({3'b000, src_x}) + $signed({cfg.offset_x[cab_pkg::OFFSET_W-1], cfg.offset_x});
      by_in = $signed({3'b000, src_y}) + $signed({cfg.offset_y[cab_pkg::OFFSET_W-1], cfg.offset_y});
      wc_in = (32'(cfg.dest_width) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.dest_width;
      hc_in = (32'(cfg.dest_height) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.dest_height;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         bx_ff    <= bx_in;
         by_ff    <= by_in;
         wc_ff    <= wc_in;
         hc_ff    <= hc_in;
         last1_ff <= last_in;
      end
   end

   // Stage 2: clip test and row times stride.
   logic              inside2_ff, inside2_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DIM_W-1:0]  col2_ff;
   logic              last2_ff;

   always_comb begin
      inside2_in = !bx_ff[POS_W-1] && !by_ff[POS_W-1]
                   && ($unsigned(bx_ff) < {2'b00, wc_ff})
                   && ($unsigned(by_ff) < {2'b00, hc_ff});
      prod_in = by_ff[DIM_W-1:0] * wc_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[1]) begin
         inside2_ff <= inside2_in;
         prod_ff    <= prod_in;
         col2_ff    <= bx_ff[DIM_W-1:0];
         last2_ff   <= last1_ff;
      end
   end

   // Stage 3: add the column, zero the address of a clipped pixel.
   logic                      inside3_ff;
   logic [cab_pkg::ADDR_W-1:0] addr3_ff, addr3_in;
   logic                      last3_ff;

   always_comb begin
      addr3_in = inside2_ff ? cab_pkg::ADDR_W'(prod_ff + PROD_W'(col2_ff)) : '0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[2]) begin
         inside3_ff <= inside2_ff;
         addr3_ff   <= addr3_in;
         last3_ff   <= last2_ff;
      end
   end

   // Stage 4: output register.
   logic                       we4_ff;
   logic [cab_pkg::ADDR_W-1:0] addr4_ff;
   logic                       last4_ff;

   always_ff @(posedge clock) begin
      if (ctrl.en[3]) begin
         we4_ff   <= inside3_ff;
         addr4_ff <= addr3_ff;
         last4_ff <= last3_ff;
      end
   end

   assign inside_s3    = inside3_ff;
   assign write_enable = we4_ff;
   assign dest_address = addr4_ff;
   assign last_out     = last4_ff;

endmodule

`default_nettype wire

### rtl/cab_blend.sv
`timescale 1ns / 1ps
`default_nettype none

module cab_blend (
   input  wire logic                             clock,
   input  wire cab_pkg::stage_ctrl_type          ctrl,
   input  wire logic [cab_pkg::ALPHA_W-1:0]      global_alpha,
   input  wire logic [cab_pkg::COLOR_W-1:0]      src_color,
   input  wire logic [cab_pkg::COLOR_W-1:0]      dst_color,
   input  wire logic                             inside_s3,
   output logic [cab_pkg::COLOR_W-1:0]           out_color
);

   localparam int AW = cab_pkg::ALPHA_W;
   localparam int CW = cab_pkg::COLOR_W;
   localparam int PW = 2 * AW;

   // Stage 1: source alpha times global alpha.
   logic [CW-1:0] src1_ff, dst1_ff;
   logic [PW-1:0] mul1_ff;
   logic          sopaque1_ff;
   logic [AW-1:0] ga1_ff;

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         src1_ff     <= src_color;
         dst1_ff     <= dst_color;
         mul1_ff     <= src_color[31:24] * global_alpha;
         sopaque1_ff <= (src_color[31:24] == cab_pkg::ALPHA_FULL);
         ga1_ff      <= global_alpha;
      end
   end

   // Stage 2: effective alpha.
   logic [CW-1:0] src2_ff, dst2_ff;
   logic [AW-1:0] a2_ff, a2_in;

   always_comb begin
      a2_in = sopaque1_ff ? ga1_ff : cab_pkg::div255(mul1_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[1]) begin
         src2_ff <= src1_ff;
         dst2_ff <= dst1_ff;
         a2_ff   <= a2_in;
      end
   end

   // Stage 3: per-channel products for source and destination weights.
   logic [CW-1:0] src3_ff;
   logic          copy3_ff;
   logic [PW-1:0] ps3_ff [3];
   logic [PW-1:0] pd3_ff [3];
   logic [AW-1:0] inv_a;

   assign inv_a = cab_pkg::ALPHA_FULL - a2_ff;

   always_ff @(posedge clock) begin
      if (ctrl.en[2]) begin
         src3_ff  <= src2_ff;
         copy3_ff <= (a2_ff == cab_pkg::ALPHA_FULL);
         for (int c = 0; c < 3; c++) begin
            ps3_ff[c] <= src2_ff[c*AW +: AW] * a2_ff;
            pd3_ff[c] <= dst2_ff[c*AW +: AW] * inv_a;
         end
      end
   end

   // Stage 4: sum the scaled terms, pick copy or blend, zero when clipped.
   logic [CW-1:0] color4_ff, color4_in;
   logic [CW-1:0] blend;

   always_comb begin
      blend = {cab_pkg::ALPHA_FULL, {3*AW{1'b0}}};
      for (int c = 0; c < 3; c++) begin
         blend[c*AW +: AW] = ps3_ff[c][PW-1:AW] + pd3_ff[c][PW-1:AW];
      end
      if (!inside_s3) begin
         color4_in = '0;
      end else if (copy3_ff) begin
         color4_in = src3_ff;
      end else begin
         color4_in = blend;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[3]) begin
         color4_ff <= color4_in;
      end
   end

   assign out_color = color4_ff;

endmodule

`default_nettype wire

### rtl/clipped_argb_alpha_blit_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A request accepted on the req_ port moves through the four register stages in
// turn before its result is offered on the rsp_ port.
// Throughput: one pixel per cycle; each of the four register stages loads whenever
// it is empty or its content moves on, so a held result stalls the input only
// once all four stages are full.
// Reset (synchronous, active high) empties the pipeline and loads the
// configuration defaults: offsets 0, size 4096 by 4096, global alpha 255.

`include "clipped_argb_alpha_blit_unit_defines.svh"

module clipped_argb_alpha_blit_unit #(
   parameter int MAX_DIM = cab_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // src_color[31:0], dst_color[63:32], src_x[75:64], src_y[87:76]
   input  wire logic [87:0] req_tdata,
   // last_in
   input  wire logic        req_tlast,
   // Result stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // dest_address[23:0], out_color[55:24]
   output logic [55:0]      rsp_tdata,
   // write_enable
   output logic             rsp_tuser,
   // last_out
   output logic             rsp_tlast,
   // Configuration writes.
   input  wire logic                           csr_we,
   input  wire logic [cab_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [cab_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int NS = cab_pkg::NUM_STAGES;

   cab_pkg::cfg_type        cfg;
   cab_pkg::stage_ctrl_type ctrl;

   logic [NS-1:0] valid_ff, valid_in;
   logic [NS:0]   rdy;

   // A stage loads when it is empty or its content moves on.
   always_comb begin
      rdy[NS] = rsp_tready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      ctrl.en = rdy[NS-1:0];
      valid_in = valid_ff;
      for (int k = 0; k < NS; k++) begin
         if (rdy[k]) begin
            valid_in[k] = (k == 0) ? req_tvalid : valid_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = valid_ff[NS-1];

   cab_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   logic inside_s3;

   cab_geom #(
      .MAX_DIM (MAX_DIM)
   ) u_geom (
      .clock        (clock),
      .ctrl         (ctrl),
      .cfg          (cfg),
      .src_x        (req_tdata[75:64]),
      .src_y        (req_tdata[87:76]),
      .last_in      (req_tlast),
      .inside_s3    (inside_s3),
      .write_enable (rsp_tuser),
      .dest_address (rsp_tdata[23:0]),
      .last_out     (rsp_tlast)
   );

   cab_blend u_blend (
      .clock        (clock),
      .ctrl         (ctrl),
      .global_alpha (cfg.global_alpha),
      .src_color    (req_tdata[31:0]),
      .dst_color    (req_tdata[63:32]),
      .inside_s3    (inside_s3),
      .out_color    (rsp_tdata[55:24])
   );

   // A clipped pixel carries neither address nor color.
   `CAB_ASSERT_IMPLY(a_clip_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == 56'd0, "clipped result not zero")

   // An empty pipeline always takes a request.
   `CAB_ASSERT_IMPLY(a_empty_ready, valid_ff == '0, req_tready, "empty pipeline stalls input")

   // Without a handshake on either side the number of requests in flight holds.
   `CAB_ASSERT_NEXT(a_count_hold, !(req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready), $countones(valid_ff) == $past($countones(valid_ff)), "request lost or duplicated")

endmodule

`default_nettype wire

### dv/blit_pixel_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register-write ports of the blit unit.
// Every accepted request is turned into the pixel write it must cause, and
// every accepted result is compared with the oldest of those writes.
module blit_pixel_checker #(
   parameter int MAX_DIM = cab_pkg::MAX_DIM_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [87:0]                    req_tdata,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [55:0]                    rsp_tdata,
   input  logic                           rsp_tuser,
   input  logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [cab_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cab_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatch_count,
   output int                             pending_count
);

   typedef struct packed {
      logic                        write_enable;
      logic [cab_pkg::ADDR_W-1:0]  dest_address;
      logic [cab_pkg::COLOR_W-1:0] out_color;
      logic                        last_out;
   } blit_pixel_type;

   // Local copy of the register file, tracked from the write port.
   cab_pkg::cfg_type blit_regs;

   // Pixel writes still owed by the block, oldest first.
   blit_pixel_type predicted_pixels[$];

   // Offsets the source position, clips it, addresses it and blends the pixel.
   function automatic blit_pixel_type blend_and_clip(input cab_pkg::cfg_type regs,
                                                     input logic [31:0] src,
                                                     input logic [31:0] dst,
                                                     input logic [11:0] col,
                                                     input logic [11:0] row,
                                                     input logic last);
      blit_pixel_type px;
      int w, h, bx, by, alpha, s, d, mixed, k;
      px = '0;
      px.last_out = last;
      w = int'(regs.dest_width);
      h = int'(regs.dest_height);
      if (w > MAX_DIM) w = MAX_DIM;
      if (h > MAX_DIM) h = MAX_DIM;
      bx = int'(col) + int'($signed(regs.offset_x));
      by = int'(row) + int'($signed(regs.offset_y));
      if (bx < 0 || by < 0 || bx >= w || by >= h) return px;

      px.write_enable = 1'b1;
      px.dest_address = 24'(bx + by * w);

      // A translucent source pixel scales the global alpha down.
      alpha = int'(regs.global_alpha);
      if (src[31:24] != 8'hff) alpha = int'(src[31:24]) * alpha / 255;
      if (alpha == 255) begin
         px.out_color = src;
         return px;
      end

      px.out_color[31:24] = 8'hff;
      for (k = 0; k < 24; k += 8) begin
         s = int'(src[k +: 8]);
         d = int'(dst[k +: 8]);
         mixed = ((s * alpha) >> 8) + ((d * (255 - alpha)) >> 8);
         px.out_color[k +: 8] = 8'(mixed);
      end
      return px;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] expected,
                                input logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s expected %h, actual %h", $time, field, expected, actual);
         mismatch_count = mismatch_count + 1;
      end
   endtask

   always @(posedge clock) begin : watch
      blit_pixel_type want;
      if (reset) begin
         blit_regs.offset_x     <= '0;
         blit_regs.offset_y     <= '0;
         blit_regs.dest_width   <= cab_pkg::DIM_RESET;
         blit_regs.dest_height  <= cab_pkg::DIM_RESET;
         blit_regs.global_alpha <= cab_pkg::ALPHA_FULL;
         mismatch_count = 0;
      end else begin
         // Register writes take effect for requests after this edge.
         if (csr_we) begin
            case (csr_index)
               cab_pkg::CSR_OFFSET_X: blit_regs.offset_x <= csr_wdata;
               cab_pkg::CSR_OFFSET_Y: blit_regs.offset_y <= csr_wdata;
               cab_pkg::CSR_DEST_WIDTH:
                  blit_regs.dest_width <= csr_wdata[cab_pkg::DIM_W-1:0];
               cab_pkg::CSR_DEST_HEIGHT:
                  blit_regs.dest_height <= csr_wdata[cab_pkg::DIM_W-1:0];
               cab_pkg::CSR_GLOBAL_ALPHA:
                  blit_regs.global_alpha <= csr_wdata[cab_pkg::ALPHA_W-1:0];
               default: ;
            endcase
         end

         // Check an accepted result against the oldest predicted write.
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_pixels.size() == 0) begin
               $display("%0t: result with no request outstanding: tdata %h user %b last %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = predicted_pixels.pop_front();
               compare_field("write_enable", 32'(want.write_enable), 32'(rsp_tuser));
               compare_field("dest_address", 32'(want.dest_address),
                             32'(rsp_tdata[cab_pkg::ADDR_W-1:0]));
               compare_field("out_color", want.out_color, rsp_tdata[55:24]);
               compare_field("last_out", 32'(want.last_out), 32'(rsp_tlast));
            end
         end

         // Predict the write that an accepted request must cause.
         if (req_tvalid && req_tready)
            predicted_pixels.push_back(blend_and_clip(blit_regs, req_tdata[31:0],
                                                      req_tdata[63:32], req_tdata[75:64],
                                                      req_tdata[87:76], req_tlast));
      end
      pending_count = predicted_pixels.size();
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_PIXELS    = 112;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [87:0]                    req_tdata;
   logic                           req_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [55:0]                    rsp_tdata;
   logic                           rsp_tuser;
   logic                           rsp_tlast;
   logic                           csr_we;
   logic [cab_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [cab_pkg::CSR_DATA_W-1:0] csr_wdata;

   int mismatch_count;
   int pending_count;
   int cycle_count = 0;

   // Destination setup as last written, used to aim source positions.
   int cur_ox = 0;
   int cur_oy = 0;
   int cur_w  = 4096;
   int cur_h  = 4096;

   bit steady_feed     = 1'b0;
   bit hold_off_wanted = 1'b0;

   clipped_argb_alpha_blit_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   blit_pixel_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Runaway guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("clipped_argb_alpha_blit_unit: mismatch");
         $finish;
      end
   end

   // Mostly no idling, often a short gap, now and then a long one.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Source position aimed near the destination, so that edges get hit.
   function automatic logic [11:0] pick_coord(input int offset, input int span);
      int r, target, pos;
      r = $urandom_range(99);
      if (span > 4096) span = 4096;
      target = int'($urandom_range(span + 8)) - 4;
      pos = target - offset;
      if (r < 5) return (r < 3) ? 12'd0 : 12'hfff;
      if (r < 25 || pos < 0 || pos > 4095) return 12'($urandom);
      return 12'(pos);
   endfunction

   function automatic int pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 4) return 0;
      if (r < 12) return $urandom_range(4097, 8191);
      if (r < 22) return 4096;
      if (r < 28) return 1;
      if (r < 75) return $urandom_range(2, 300);
      return $urandom_range(1, 4096);
   endfunction

   function automatic int pick_offset();
      int r;
      r = $urandom_range(99);
      if (r < 5) return -4096;
      if (r < 10) return 4096;
      if (r < 15) return int'($signed(14'($urandom)));
      return int'($urandom_range(600)) - 300;
   endfunction

   task automatic write_csr(input logic [cab_pkg::CSR_IDX_W-1:0] idx,
                            input logic [cab_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic apply_config(input int ox, input int oy, input int w, input int h,
                               input int ga);
      write_csr(cab_pkg::CSR_OFFSET_X, 14'(ox));
      write_csr(cab_pkg::CSR_OFFSET_Y, 14'(oy));
      write_csr(cab_pkg::CSR_DEST_WIDTH, {1'b0, 13'(w)});
      write_csr(cab_pkg::CSR_DEST_HEIGHT, {1'b0, 13'(h)});
      write_csr(cab_pkg::CSR_GLOBAL_ALPHA, {6'b0, 8'(ga)});
      cur_ox = ox;
      cur_oy = oy;
      cur_w  = w;
      cur_h  = h;
   endtask

   // Offers one request and returns at the edge where it is accepted.
   task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst,
                             input logic [11:0] col, input logic [11:0] row,
                             input logic last);
      int gap;
      gap = steady_feed ? 0 : idle_cycles();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {row, col, dst, src};
      req_tlast  = last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops offering and lets the pipeline empty before registers change.
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (cab_pkg::NUM_STAGES + 2) @(negedge clock);
   endtask

   // Result side: ready in runs of random length, one long hold-off on demand.
   initial begin : result_sink
      int run, stall;
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         if (hold_off_wanted && !hold_done) begin
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         run = ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(20, 80);
         rsp_tready = 1'b1;
         repeat (run) @(negedge clock);
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int phase, n, r;
      logic [31:0] src;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Defaults after reset: opaque, clear and partial source alpha at the corners of the largest surface.
      send_pixel(32'hffffffff, 32'h00000000, 12'd0, 12'd0, 1'b0);
      send_pixel(32'h00000000, 32'hffffffff, 12'd4095, 12'd4095, 1'b0);
      send_pixel(32'h80123456, 32'h89abcdef, 12'd4095, 12'd0, 1'b0);
      send_pixel(32'hfe00ff00, 32'h00ff00ff, 12'd0, 12'd4095, 1'b1);
      settle();

      // Extreme offsets with an oversized destination: everything falls outside.
      apply_config(-4096, 4096, 8191, 4097, 0);
      send_pixel(32'hffffffff, 32'h12345678, 12'd4095, 12'd0, 1'b1);
      send_pixel(32'h7f00ff00, 32'hffffffff, 12'd0, 12'd0, 1'b0);
      settle();

      // Small destination: last pixel inside, one past the right and bottom edges, source origin.
      // Zero global alpha leaves only the scaled destination color.
      apply_config(10, 5, 100, 50, 0);
      send_pixel(32'hffffffff, 32'h80ff4020, 12'd89, 12'd44, 1'b0);
      send_pixel(32'hffffffff, 32'h80ff4020, 12'd90, 12'd44, 1'b0);
      send_pixel(32'hffffffff, 32'h80ff4020, 12'd89, 12'd45, 1'b0);
      send_pixel(32'h40a0b0c0, 32'hffffffff, 12'd0, 12'd0, 1'b1);
      settle();

      // Zero width, then zero height: every pixel is clipped.
      apply_config(0, 0, 0, 4096, 128);
      send_pixel(32'hffffffff, 32'hffffffff, 12'd0, 12'd0, 1'b1);
      settle();
      apply_config(0, 0, 4096, 0, 128);
      send_pixel(32'hffffffff, 32'hffffffff, 12'd0, 12'd0, 1'b1);
      settle();

      // The most negative and most positive offsets, taken as raw 14-bit values.
      apply_config(-8192, 8191, 4096, 4096, 255);
      send_pixel(32'hffffffff, 32'h00000000, 12'd4095, 12'd4095, 1'b0);
      send_pixel(32'h12345678, 32'h9abcdef0, 12'd0, 12'd0, 1'b1);
      settle();

      // Partial global alpha with opaque, clear and half source alpha;
      // the far corner gives the highest address.
      apply_config(0, 0, 4096, 4096, 200);
      send_pixel(32'hff336699, 32'h00aa5500, 12'd4095, 12'd4095, 1'b0);
      send_pixel(32'h00ffffff, 32'h12345678, 12'd1, 12'd1, 1'b0);
      send_pixel(32'h80ff00ff, 32'hff00ff00, 12'd2, 12'd3, 1'b0);
      send_pixel(32'hfeffffff, 32'h00000000, 12'd4095, 12'd1, 1'b1);
      settle();

      // Random images, each under its own destination setup.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         r = $urandom_range(99);
         apply_config(pick_offset(), pick_offset(), pick_dim(), pick_dim(),
                      (r < 20) ? 255 : (r < 30) ? 0 : int'($urandom_range(255)));
         steady_feed = (phase % 3 == 1);
         if (phase == 2) hold_off_wanted = 1'b1;
         for (n = 0; n < PHASE_PIXELS; n++) begin
            r = $urandom_range(99);
            src = $urandom;
            if (r < 25) src[31:24] = 8'hff;
            else if (r < 35) src[31:24] = 8'h00;
            else if (r < 40) src[31:24] = 8'hfe;
            send_pixel(src, $urandom, pick_coord(cur_ox, cur_w), pick_coord(cur_oy, cur_h),
                       (n == PHASE_PIXELS - 1) || ($urandom_range(99) < 3));
         end
         settle();
      end

      repeat (cab_pkg::NUM_STAGES * 4) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("clipped_argb_alpha_blit_unit: match");
      end else begin
         $display("clipped_argb_alpha_blit_unit: mismatch");
      end
      $finish;
   end

endmodule
